>>> rtl/core/stun_message_validator_defines.svh
// Assertion helpers for the validator RTL.
`ifndef STUN_MESSAGE_VALIDATOR_DEFINES_SVH
`define STUN_MESSAGE_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define STUNV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stunv assertion failed");

// Next-cycle implication, disabled while reset is high.
`define STUNV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stunv assertion failed");

`else

`define STUNV_ASSERT_NOW(label, clk, rst, ante, cons)
`define STUNV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/stunv_pkg.sv
package stunv_pkg;

  localparam int HEADER_BYTES      = 20;
  localparam int ATTR_HEADER_BYTES = 4;

  localparam logic [16:0] POS_MAX    = 17'h1FFFF;
  localparam logic [13:0] CNT_MAX    = 14'h3FFF;
  localparam logic [16:0] ALIGN_ADD  = 17'(ATTR_HEADER_BYTES + 3);
  localparam logic [16:0] ALIGN_MASK = ~17'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TYPE    = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  localparam logic [15:0] MT_BIND_REQ        = 16'h0001;
  localparam logic [15:0] MT_BIND_RESP       = 16'h0101;
  localparam logic [15:0] MT_BIND_ERR        = 16'h0111;
  localparam logic [15:0] MT_SECRET_REQ      = 16'h0002;
  localparam logic [15:0] MT_SECRET_RESP     = 16'h0102;
  localparam logic [15:0] MT_SECRET_ERR      = 16'h0112;

  localparam logic [15:0] ATTR_LAST_STD      = 16'h000B;
  localparam logic [15:0] ATTR_XOR_ONLY      = 16'h8020;

  localparam logic [15:0] WANTED_RESET   = 16'h0001;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } stunv_byte_t;

  function automatic logic type_known(input logic [15:0] t);
    return (t == MT_BIND_REQ)   || (t == MT_BIND_RESP)   || (t == MT_BIND_ERR) ||
           (t == MT_SECRET_REQ) || (t == MT_SECRET_RESP) || (t == MT_SECRET_ERR);
  endfunction

  // A nonzero remainder shorter than an attribute header cannot hold one.
  function automatic logic tail_short(input logic [15:0] rem);
    return (rem != 16'd0) && (rem < 16'(ATTR_HEADER_BYTES));
  endfunction

endpackage

>>> rtl/core/stunv_if.sv
interface stunv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface stunv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] message_type;
  logic [13:0] attribute_count;
  logic [13:0] unknown_count;
  logic        found;
  logic [16:0] found_offset;

  modport source(output valid, output status, output message_type,
                 output attribute_count, output unknown_count, output found,
                 output found_offset, input ready);
  modport sink(input valid, input status, input message_type,
               input attribute_count, input unknown_count, input found,
               input found_offset, output ready);
endinterface

>>> rtl/core/stunv_in_reg.sv
module stunv_in_reg
  import stunv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  stunv_in_if.sink    msg,
  output logic        item_valid,
  output stunv_byte_t item,
  input  logic        item_take
);

  // The slot can refill in the same cycle that the parser drains it.
  assign msg.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      item.data_byte <= msg.data_byte;
      item.last_byte <= msg.last_byte;
    end
  end

endmodule

>>> rtl/core/stunv_parse.sv
module stunv_parse
  import stunv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  stunv_byte_t item,
  output logic        item_take,
  input  logic [15:0] wanted,
  stunv_out_if.source report
);

  logic [16:0] byte_position;
  logic [15:0] header_type;
  logic [15:0] header_length;
  logic [15:0] remaining_length;
  logic [16:0] attribute_start;
  logic [23:0] attr_bytes;
  logic [13:0] attribute_counter;
  logic [13:0] unknown_counter;
  logic        match_seen;
  logic [16:0] match_offset;
  logic        overrun_flag;

  logic [16:0] byte_position_next;
  logic [15:0] header_type_next;
  logic [15:0] header_length_next;
  logic [15:0] remaining_length_next;
  logic [16:0] attribute_start_next;
  logic [23:0] attr_bytes_next;
  logic [13:0] attribute_counter_next;
  logic [13:0] unknown_counter_next;
  logic        match_seen_next;
  logic [16:0] match_offset_next;
  logic        overrun_flag_next;

  logic [31:0] attr_word;
  logic [15:0] atype;
  logic [16:0] total;
  logic [17:0] start_wide;
  logic [17:0] pos_wide;
  logic [16:0] count;
  logic [1:0]  status_next;

  assign item_take = item_valid && (!item.last_byte || !report.valid || report.ready);

  assign attr_word  = {attr_bytes, item.data_byte};
  assign atype      = attr_word[31:16];
  assign total      = ({1'b0, attr_word[15:0]} + ALIGN_ADD) & ALIGN_MASK;
  assign start_wide = {1'b0, attribute_start};
  assign pos_wide   = {1'b0, byte_position};
  assign count      = (byte_position == POS_MAX) ? byte_position : byte_position + 17'd1;

  always_comb begin
    header_type_next       = header_type;
    header_length_next     = header_length;
    remaining_length_next  = remaining_length;
    attribute_start_next   = attribute_start;
    attr_bytes_next        = attr_bytes;
    attribute_counter_next = attribute_counter;
    unknown_counter_next   = unknown_counter;
    match_seen_next        = match_seen;
    match_offset_next      = match_offset;
    overrun_flag_next      = overrun_flag;

    if (byte_position < 17'd2) begin
      header_type_next = {header_type[7:0], item.data_byte};
    end else if (byte_position < 17'd4) begin
      header_length_next = {header_length[7:0], item.data_byte};
    end else if (byte_position == 17'(HEADER_BYTES - 1)) begin
      remaining_length_next = header_length;
      attribute_start_next  = 17'(HEADER_BYTES);
      if (tail_short(header_length)) begin
        overrun_flag_next = 1'b1;
      end
    end else if (byte_position >= 17'(HEADER_BYTES) && remaining_length != 16'd0 &&
                 !overrun_flag && byte_position >= attribute_start &&
                 pos_wide < start_wide + 18'(ATTR_HEADER_BYTES)) begin
      attr_bytes_next = attr_word[23:0];
      // The fourth header byte closes the attribute and steps to the next one.
      if (pos_wide == start_wide + 18'(ATTR_HEADER_BYTES - 1)) begin
        if (total > {1'b0, remaining_length}) begin
          overrun_flag_next = 1'b1;
        end else begin
          if (atype > ATTR_LAST_STD && atype != ATTR_XOR_ONLY &&
              unknown_counter < CNT_MAX) begin
            unknown_counter_next = unknown_counter + 14'd1;
          end
          if (atype == wanted && !match_seen) begin
            match_seen_next   = 1'b1;
            match_offset_next = attribute_start;
          end
          if (attribute_counter < CNT_MAX) begin
            attribute_counter_next = attribute_counter + 14'd1;
          end
          remaining_length_next = remaining_length - total[15:0];
          attribute_start_next  = attribute_start + total;
          if (tail_short(remaining_length - total[15:0])) begin
            overrun_flag_next = 1'b1;
          end
        end
      end
    end

    byte_position_next = count;

    if (count < 17'(HEADER_BYTES)) begin
      status_next = ST_LENGTH;
    end else if (!type_known(header_type_next)) begin
      status_next = ST_TYPE;
    end else if (count == POS_MAX ||
                 {1'b0, header_length_next} != count - 17'(HEADER_BYTES)) begin
      status_next = ST_LENGTH;
    end else if (overrun_flag_next) begin
      status_next = ST_OVERRUN;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (item_take && item.last_byte)) begin
      byte_position     <= '0;
      header_type       <= '0;
      header_length     <= '0;
      remaining_length  <= '0;
      attribute_start   <= '0;
      attr_bytes        <= '0;
      attribute_counter <= '0;
      unknown_counter   <= '0;
      match_seen        <= 1'b0;
      match_offset      <= '0;
      overrun_flag      <= 1'b0;
    end else if (item_take) begin
      byte_position     <= byte_position_next;
      header_type       <= header_type_next;
      header_length     <= header_length_next;
      remaining_length  <= remaining_length_next;
      attribute_start   <= attribute_start_next;
      attr_bytes        <= attr_bytes_next;
      attribute_counter <= attribute_counter_next;
      unknown_counter   <= unknown_counter_next;
      match_seen        <= match_seen_next;
      match_offset      <= match_offset_next;
      overrun_flag      <= overrun_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (item_take && item.last_byte) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last_byte) begin
      report.status       <= status_next;
      report.message_type <= header_type_next;
      if (status_next == ST_OK || status_next == ST_OVERRUN) begin
        report.attribute_count <= attribute_counter_next;
        report.unknown_count   <= unknown_counter_next;
        report.found           <= match_seen_next;
        report.found_offset    <= match_seen_next ? match_offset_next : 17'd0;
      end else begin
        report.attribute_count <= '0;
        report.unknown_count   <= '0;
        report.found           <= 1'b0;
        report.found_offset    <= '0;
      end
    end
  end

endmodule

>>> rtl/core/stun_message_validator.sv
// Streaming STUN message checker.
// The msg channel carries one message byte per transaction in wire order,
// with last_byte set on the final byte of the message. The report channel
// carries one transaction per message: status, the header type, attribute
// and unknown-attribute counts, and whether and where the first attribute
// of type wanted_attr_type was seen. cfg_we with cfg_wdata loads
// wanted_attr_type; write it only between messages.
// A byte is taken into an input register, from which the parser consumes it,
// so one byte per cycle is sustained while the report channel does not stall.
// The report valid is registered when the parser takes the final byte, which
// it does only while the report channel is free. The rate is set by the single
// parser stage, which updates all per-message state for one byte per cycle.
// A stalled report holds the final byte of the next message in the input
// register; bytes that produce no report keep flowing meanwhile.
// Reset clears all message state and the report valid, and loads
// wanted_attr_type with 1. The parser state is cleared after every message.
`include "stun_message_validator_defines.svh"

module stun_message_validator
  import stunv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  stunv_in_if.sink    msg,
  stunv_out_if.source report,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        item_valid;
  stunv_byte_t item;
  logic        item_take;
  logic [15:0] wanted_attr_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_attr_type <= WANTED_RESET;
    end else if (cfg_we) begin
      wanted_attr_type <= cfg_wdata;
    end
  end

  stunv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  stunv_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .wanted     (wanted_attr_type),
    .report     (report)
  );

  `STUNV_ASSERT_NEXT(a_item_held, clk, rst, item_valid && !item_take, item_valid)
  `STUNV_ASSERT_NOW(a_ready_only_stalled, clk, rst, !msg.ready, item_valid)
  `STUNV_ASSERT_NOW(a_error_clears_counts, clk, rst,
    report.valid && (report.status == ST_TYPE || report.status == ST_LENGTH),
    report.attribute_count == 14'd0 && report.unknown_count == 14'd0 && !report.found)
  `STUNV_ASSERT_NOW(a_offset_needs_found, clk, rst, report.valid && !report.found,
    report.found_offset == 17'd0)
  `STUNV_ASSERT_NOW(a_unknown_bounded, clk, rst, report.valid,
    report.unknown_count <= report.attribute_count)

endmodule
